// ----- hdl/mkslp_pkg.sv -----
// Package for the matrix keypad scanner with long-press detection.
// Phase codes, register indexes, widths and reset values. No dependencies.
`default_nettype none

package mkslp_pkg;

   localparam int DefaultRows = 4;
   localparam int DefaultCols = 4;

   localparam int ColInW   = 4;    // column lines sampled per word
   localparam int ColIdxW  = 2;    // held column index
   localparam int RowOutW  = 2;    // row_select width
   localparam int CodeW    = 7;
   localparam int TimerW   = 11;
   localparam int LongW    = 11;
   localparam int SettleW  = 8;
   localparam int BeepW    = 10;
   localparam int CsrDataW = 11;
   localparam int CsrIdxW  = 2;

   localparam logic [LongW-1:0]   LongPressReset = 11'd1000;
   localparam logic [SettleW-1:0] SettleReset    = 8'd20;
   localparam logic [BeepW-1:0]   BeepReset      = 10'd100;

   localparam logic [CodeW-1:0] ShortBase = 7'd1;
   localparam logic [CodeW-1:0] LongBase  = 7'd101;

   typedef enum logic [5:0] {
      PH_SCAN   = 6'b000001,
      PH_BEEP1  = 6'b000010,
      PH_HOLD   = 6'b000100,
      PH_SETTLE = 6'b001000,
      PH_BEEP2  = 6'b010000,
      PH_WAIT   = 6'b100000
   } phase_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_SETTLE     = 2'd1,
      CSR_BEEP       = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ----- hdl/matrix_keypad_scanner_long_press_unit.sv -----
// Top level: 4x4 active-low keypad scanner with beep, settle and long-press timing.
// Uses mkslp_pkg for phase codes, register indexes and widths.
//
//   channel | dir | ports                                   | handshake
//   req     | in  | req_column_levels                       | req_valid / req_ready
//   rsp     | out | rsp_row_select, rsp_beep_on,            | rsp_valid / rsp_ready
//           |     | rsp_key_valid, rsp_key_code             |
//   csr     | in  | csr_index, csr_write_data               | csr_write_enable
//
// One word in, one word out; one word per cycle sustained while rsp_ready stays high. The phase update and
// the result are computed combinationally from the state registers and the sampled
// columns and land in the result register on acceptance, shown on rsp_* in the next cycle.
// req_ready is high while the result register is empty or being drained this cycle.
// Synchronous reset clears phase, timer, row counter and restores register defaults.
`default_nettype none

module matrix_keypad_scanner_long_press_unit #(
   parameter int ROWS = mkslp_pkg::DefaultRows,
   parameter int COLS = mkslp_pkg::DefaultCols
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mkslp_pkg::ColInW-1:0]  req_column_levels,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mkslp_pkg::RowOutW-1:0]      rsp_row_select,
   output logic                               rsp_beep_on,
   output logic                               rsp_key_valid,
   output logic [mkslp_pkg::CodeW-1:0]        rsp_key_code,
   input  wire logic                          csr_write_enable,
   input  wire logic [mkslp_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [mkslp_pkg::CsrDataW-1:0] csr_write_data
);
   import mkslp_pkg::*;

   localparam int RowW    = $clog2(ROWS);
   localparam int NumScan = (COLS < ColInW) ? COLS : ColInW;
   localparam logic [RowW-1:0]   RowLast  = RowW'(ROWS - 1);
   localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

   // configuration
   logic [LongW-1:0]   long_press_ff;
   logic [SettleW-1:0] settle_ff;
   logic [BeepW-1:0]   beep_ff;

   // scanner state
   phase_type          phase_ff, phase_in;
   logic [RowW-1:0]    row_ff, row_in;
   logic [ColIdxW-1:0] held_ff, held_in;
   logic [TimerW-1:0]  timer_ff, timer_in;
   logic [CodeW-1:0]   pending_ff, pending_in;

   // result register
   logic               rsp_valid_ff;
   logic [RowOutW-1:0] row_select_ff;
   logic               beep_on_ff, beep_on_in;
   logic               key_valid_ff, key_valid_in;
   logic [CodeW-1:0]   key_code_ff, key_code_in;

   logic                req_fire;
   logic                hit;
   logic [ColIdxW-1:0]  hit_col;
   logic                held_down;
   logic [TimerW-1:0]   timer_inc;
   logic [TimerW-1:0]   timer_sat;
   logic [TimerW-1:0]   beep_len;
   logic [TimerW-1:0]   settle_len;
   logic [7:0]          code_sum;
   logic [CodeW-1:0]    short_code;
   logic [CodeW-1:0]    long_code;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // lowest low column on the driven row wins
   always_comb begin
      hit     = 1'b0;
      hit_col = '0;
      for (int i = NumScan - 1; i >= 0; i--) begin
         if (!req_column_levels[i]) begin
            hit     = 1'b1;
            hit_col = ColIdxW'(i);
         end
      end
   end

   assign held_down  = !req_column_levels[held_ff];
   assign timer_inc  = timer_ff + TimerW'(1);
   assign timer_sat  = (timer_ff == TimerMax) ? TimerMax : timer_inc;
   assign beep_len   = TimerW'(beep_ff);
   assign settle_len = TimerW'(settle_ff);
   assign code_sum   = 8'(COLS) * 8'(row_ff) + 8'(held_ff);
   assign short_code = CodeW'(code_sum + 8'(ShortBase));
   assign long_code  = CodeW'(code_sum + 8'(LongBase));

   always_comb begin
      phase_in     = phase_ff;
      row_in       = row_ff;
      held_in      = held_ff;
      timer_in     = timer_ff;
      pending_in   = pending_ff;
      beep_on_in   = 1'b0;
      key_valid_in = 1'b0;
      key_code_in  = '0;
      unique case (phase_ff)
         PH_SCAN: begin
            if (hit) begin
               held_in = hit_col;
               if (beep_ff == '0) begin
                  phase_in = PH_HOLD;
                  timer_in = '0;
               end else begin
                  beep_on_in = 1'b1;
                  // a one-sample beep ends on the press sample itself
                  if (beep_ff == BeepW'(1)) begin
                     phase_in = PH_HOLD;
                     timer_in = '0;
                  end else begin
                     phase_in = PH_BEEP1;
                     timer_in = TimerW'(1);
                  end
               end
            end else begin
               row_in = (row_ff == RowLast) ? '0 : row_ff + RowW'(1);
            end
         end
         PH_BEEP1: begin
            if (timer_inc >= beep_len) begin
               phase_in = PH_HOLD;
               timer_in = '0;
            end else begin
               timer_in   = timer_inc;
               beep_on_in = 1'b1;
            end
         end
         PH_HOLD: begin
            if (!held_down) begin
               pending_in = short_code;
               timer_in   = '0;
               if (settle_ff == '0) begin
                  key_valid_in = 1'b1;
                  key_code_in  = short_code;
                  phase_in     = PH_SCAN;
                  row_in       = '0;
               end else begin
                  phase_in = PH_SETTLE;
               end
            end else if (timer_sat >= TimerW'(long_press_ff)) begin
               pending_in = long_code;
               timer_in   = '0;
               if (beep_ff == '0) begin
                  key_valid_in = 1'b1;
                  key_code_in  = long_code;
                  phase_in     = PH_WAIT;
               end else begin
                  beep_on_in = 1'b1;
                  if (beep_ff == BeepW'(1)) begin
                     key_valid_in = 1'b1;
                     key_code_in  = long_code;
                     phase_in     = PH_WAIT;
                  end else begin
                     phase_in = PH_BEEP2;
                     timer_in = TimerW'(1);
                  end
               end
            end else begin
               timer_in = timer_sat;
            end
         end
         PH_SETTLE: begin
            if (timer_inc >= settle_len) begin
               key_valid_in = 1'b1;
               key_code_in  = pending_ff;
               phase_in     = PH_SCAN;
               row_in       = '0;
               timer_in     = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_BEEP2: begin
            if (timer_inc >= beep_len) begin
               key_valid_in = 1'b1;
               key_code_in  = pending_ff;
               phase_in     = PH_WAIT;
               timer_in     = '0;
            end else begin
               timer_in   = timer_inc;
               beep_on_in = 1'b1;
            end
         end
         PH_WAIT: begin
            if (!held_down) begin
               phase_in = PH_SCAN;
               row_in   = '0;
            end
         end
         default: begin
            phase_in = PH_SCAN;
            row_in   = '0;
            timer_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LongPressReset;
         settle_ff     <= SettleReset;
         beep_ff       <= BeepReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LONG_PRESS: long_press_ff <= LongW'(csr_write_data);
            CSR_SETTLE:     settle_ff     <= SettleW'(csr_write_data);
            CSR_BEEP:       beep_ff       <= BeepW'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SCAN;
         row_ff     <= '0;
         held_ff    <= '0;
         timer_ff   <= '0;
         pending_ff <= '0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         row_ff     <= row_in;
         held_ff    <= held_in;
         timer_ff   <= timer_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         row_select_ff <= RowOutW'(row_in);
         beep_on_ff    <= beep_on_in;
         key_valid_ff  <= key_valid_in;
         key_code_ff   <= key_code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_select = row_select_ff;
   assign rsp_beep_on    = beep_on_ff;
   assign rsp_key_valid  = key_valid_ff;
   assign rsp_key_code   = key_code_ff;

   // a waiting word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("result overwritten while stalled");

   // no event means a zero code
   a_idle_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !key_valid_ff |-> key_code_ff == '0)
      else $error("nonzero code without key event");

   // a reported key always leaves the scanner scanning or waiting for release
   a_event_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire && key_valid_in |=> phase_ff == PH_SCAN || phase_ff == PH_WAIT)
      else $error("key event in wrong phase");

   // a word that leaves the scanner in a beep phase carries the buzzer on
   a_beep_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !(phase_ff == PH_BEEP1 || phase_ff == PH_BEEP2) || beep_on_ff)
      else $error("beep phase without buzzer");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for matrix_keypad_scanner_long_press_unit: a virtual 4x4 keypad drives column
// words, an in-house model predicts every result word, and a checker compares them in order.
// Depends on mkslp_pkg and the block's top level; nothing else.
`timescale 1ns / 100ps

module testbench;
   import mkslp_pkg::*;

   localparam int RandomWords      = 170;
   localparam int HoldOffCycles    = 150;
   localparam int WatchdogLimit    = 3000;
   localparam int IdleSettleCycles = 4;
   localparam int MaxReported      = 10;
   localparam logic [CsrIdxW-1:0] CsrUnusedIndex = 2'd3;

   typedef struct packed {
      logic [RowOutW-1:0] row_select;
      logic               beep_on;
      logic               key_valid;
      logic [CodeW-1:0]   key_code;
   } scan_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ColInW-1:0] req_column_levels = 4'hF;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [RowOutW-1:0] rsp_row_select;
   logic rsp_beep_on;
   logic rsp_key_valid;
   logic [CodeW-1:0] rsp_key_code;
   logic csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_write_data = '0;

   // model state and register copies, reset values from the package
   phase_type scan_phase = PH_SCAN;
   logic [1:0] row_count = '0;
   logic [1:0] held_col = '0;
   logic [TimerW-1:0] hold_timer = '0;
   logic [CodeW-1:0] pending_code = '0;
   logic [LongW-1:0] long_limit = LongPressReset;
   logic [SettleW-1:0] settle_len = SettleReset;
   logic [BeepW-1:0] beep_len = BeepReset;

   logic [15:0] pressed_keys = '0;   // bit 4*row+col
   scan_report_type scan_reports[$];
   int mismatch_count = 0;
   int words_sent = 0;
   int stall_cycles = 0;
   bit idle_enable = 1'b1;
   bit hold_off_pending = 1'b0;

   matrix_keypad_scanner_long_press_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_column_levels(req_column_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_select   (rsp_row_select),
      .rsp_beep_on      (rsp_beep_on),
      .rsp_key_valid    (rsp_key_valid),
      .rsp_key_code     (rsp_key_code),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One sample of the keypad: advances the model and returns the word it must produce.
   function automatic scan_report_type scan_step(input logic [ColInW-1:0] cols);
      scan_report_type r;
      logic released;
      r = '0;
      released = cols[held_col];
      case (scan_phase)
         PH_SCAN: begin
            if (cols != 4'hF) begin
               held_col = 2'd3;
               for (int c = 3; c >= 0; c--) if (!cols[c]) held_col = 2'(c);
               if (beep_len == '0) begin
                  scan_phase = PH_HOLD;
                  hold_timer = '0;
               end else begin
                  r.beep_on = 1'b1;
                  hold_timer = 11'd1;
                  scan_phase = PH_BEEP1;
                  if (hold_timer >= beep_len) begin
                     scan_phase = PH_HOLD;
                     hold_timer = '0;
                  end
               end
            end else begin
               row_count = row_count + 2'd1;
            end
         end
         PH_BEEP1: begin
            hold_timer = hold_timer + 11'd1;
            if (hold_timer >= beep_len) begin
               scan_phase = PH_HOLD;
               hold_timer = '0;
            end else begin
               r.beep_on = 1'b1;
            end
         end
         PH_HOLD: begin
            if (released) begin
               pending_code = {3'b000, row_count, held_col} + ShortBase;
               hold_timer = '0;
               if (settle_len == '0) begin
                  r.key_valid = 1'b1;
                  r.key_code = pending_code;
                  scan_phase = PH_SCAN;
                  row_count = '0;
               end else begin
                  scan_phase = PH_SETTLE;
               end
            end else begin
               if (hold_timer != 11'h7FF) hold_timer = hold_timer + 11'd1;
               if (hold_timer >= long_limit) begin
                  pending_code = {3'b000, row_count, held_col} + LongBase;
                  hold_timer = '0;
                  if (beep_len == '0) begin
                     r.key_valid = 1'b1;
                     r.key_code = pending_code;
                     scan_phase = PH_WAIT;
                  end else begin
                     r.beep_on = 1'b1;
                     hold_timer = 11'd1;
                     scan_phase = PH_BEEP2;
                     if (hold_timer >= beep_len) begin
                        r.key_valid = 1'b1;
                        r.key_code = pending_code;
                        scan_phase = PH_WAIT;
                        hold_timer = '0;
                     end
                  end
               end
            end
         end
         PH_SETTLE: begin
            hold_timer = hold_timer + 11'd1;
            if (hold_timer >= settle_len) begin
               r.key_valid = 1'b1;
               r.key_code = pending_code;
               scan_phase = PH_SCAN;
               row_count = '0;
               hold_timer = '0;
            end
         end
         PH_BEEP2: begin
            hold_timer = hold_timer + 11'd1;
            if (hold_timer >= beep_len) begin
               r.key_valid = 1'b1;
               r.key_code = pending_code;
               scan_phase = PH_WAIT;
               hold_timer = '0;
            end else begin
               r.beep_on = 1'b1;
            end
         end
         PH_WAIT: begin
            if (released) begin
               scan_phase = PH_SCAN;
               row_count = '0;
            end
         end
         default: begin
            scan_phase = PH_SCAN;
            row_count = '0;
            hold_timer = '0;
         end
      endcase
      r.row_select = row_count;
      return r;
   endfunction

   // Column levels the virtual keypad shows for the row the block is driving now.
   function automatic logic [ColInW-1:0] column_word();
      logic [ColInW-1:0] w;
      for (int c = 0; c < 4; c++) w[c] = ~pressed_keys[4 * row_count + c];
      return w;
   endfunction

   // Mostly no gap, some short ones, a few long ones.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_column_word(input logic [ColInW-1:0] levels);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_column_levels <= levels;
      do @(posedge clock); while (!req_ready);
      scan_reports.push_back(scan_step(levels));
      words_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (scan_reports.size() != 0) @(posedge clock);
      repeat (IdleSettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIdxW-1:0] idx,
                                 input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_LONG_PRESS: long_limit = data[LongW-1:0];
         CSR_SETTLE:     settle_len = data[SettleW-1:0];
         CSR_BEEP:       beep_len = data[BeepW-1:0];
         default: ;
      endcase
   endtask

   // Upper data bits beyond the settle and beep registers are random; the block must drop them.
   task automatic configure(input logic [LongW-1:0] long_ms, input logic [SettleW-1:0] settle_ms,
                            input logic [BeepW-1:0] beep_ms);
      wait_idle();
      write_register(CSR_LONG_PRESS, long_ms);
      write_register(CSR_SETTLE, {3'($urandom_range(0, 7)), settle_ms});
      write_register(CSR_BEEP, {1'($urandom_range(0, 1)), beep_ms});
      write_register(CsrUnusedIndex, 11'($urandom_range(0, 2047)));
   endtask

   // Release until scanning, hold keys until the block latches one, then hold
   // for further words, release and send trailing words.
   task automatic press_keys(input logic [15:0] keys, input int hold, input int trailing,
                             input bit bouncy);
      pressed_keys = '0;
      while (scan_phase != PH_SCAN) send_column_word(column_word());
      pressed_keys = keys;
      while (scan_phase == PH_SCAN) send_column_word(column_word());
      repeat (hold) begin
         if (bouncy && $urandom_range(0, 14) == 0)
            send_column_word(4'($urandom_range(0, 15)));
         else
            send_column_word(column_word());
      end
      pressed_keys = '0;
      repeat (trailing) send_column_word(column_word());
   endtask

   // Reset register values: 100-sample beep, 20-sample settle, no long press in 110.
   task automatic test_reset_values();
      repeat (6) send_column_word(4'hF);
      press_keys(16'h0200, 110, 22, 1'b0);
   endtask

   task automatic test_directed_cases();
      idle_enable = 1'b0;
      configure(11'd2, 8'd0, 10'd0);
      press_keys(16'h000E, 0, 0, 1'b0);   // several columns low, lowest wins; report on release
      press_keys(16'hF000, 2, 0, 1'b0);   // all columns low, long press without beep
      press_keys(16'h8000, 0, 0, 1'b0);   // last key, short
      idle_enable = 1'b1;
      configure(11'd0, 8'd1, 10'd1);
      press_keys(16'h8000, 1, 0, 1'b0);   // zero long-press time, one-sample beeps
      press_keys(16'h0400, 0, 1, 1'b0);   // one-sample settle
   endtask

   // Largest register values, cut short by rewriting while the block is mid-press.
   task automatic test_register_extremes();
      configure(11'h7FF, 8'hFF, 10'h3FF);
      pressed_keys = 16'h0010;
      while (scan_phase == PH_SCAN) send_column_word(column_word());
      repeat (30) send_column_word(column_word());
      configure(11'h7FF, 8'hFF, 10'd0);
      repeat (20) send_column_word(column_word());
      pressed_keys = '0;
      repeat (20) send_column_word(column_word());
      configure(11'h7FF, 8'd0, 10'd0);
      repeat (3) send_column_word(column_word());
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_result_backpressure();
      idle_enable = 1'b0;
      configure(11'd6, 8'd2, 10'd2);
      hold_off_pending = 1'b1;
      repeat (3) press_keys(16'(1) << $urandom_range(0, 15), $urandom_range(0, 10), 3, 1'b0);
      idle_enable = 1'b1;
   endtask

   task automatic test_random_presses();
      int first_word;
      int settings;
      int roll;
      int hold;
      logic [15:0] keys;
      first_word = words_sent;
      settings = 0;
      while (words_sent - first_word < RandomWords) begin
         if (words_sent - first_word >= settings * 60) begin
            idle_enable = (settings % 3 != 2);
            configure(11'($urandom_range(0, 20)), 8'($urandom_range(0, 8)),
                      10'($urandom_range(0, 6)));
            settings++;
         end
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            repeat ($urandom_range(4, 12)) send_column_word(4'($urandom_range(0, 15)));
         end else begin
            keys = 16'(1) << $urandom_range(0, 15);
            if (roll < 3) keys |= 16'(1) << $urandom_range(0, 15);
            if ($urandom_range(0, 1))
               hold = $urandom_range(0, beep_len + long_limit + 2);
            else
               hold = 2 * beep_len + long_limit + $urandom_range(1, 6);
            press_keys(keys, hold, $urandom_range(0, 4), roll > 7);
         end
      end
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left = HoldOffCycles;
         end else if (stall_left == 0) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      scan_report_type want;
      scan_report_type got;
      got = {rsp_row_select, rsp_beep_on, rsp_key_valid, rsp_key_code};
      if (!reset && rsp_valid && rsp_ready) begin
         if (scan_reports.size() == 0) begin
            if (mismatch_count < MaxReported)
               $display("unexpected result word: row %0d beep %0d valid %0d code %0d",
                        got.row_select, got.beep_on, got.key_valid, got.key_code);
            mismatch_count++;
         end else begin
            want = scan_reports.pop_front();
            if (got.row_select !== want.row_select || got.beep_on !== want.beep_on ||
                got.key_valid !== want.key_valid || got.key_code !== want.key_code) begin
               if (mismatch_count < MaxReported)
                  $display("mismatch exp/act: row %0d/%0d beep %0d/%0d valid %0d/%0d code %0d/%0d",
                           want.row_select, got.row_select, want.beep_on, got.beep_on,
                           want.key_valid, got.key_valid, want.key_code, got.key_code);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed_cases();
      test_register_extremes();
      test_result_backpressure();
      test_random_presses();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && scan_reports.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/mkslp_pkg.sv
hdl/matrix_keypad_scanner_long_press_unit.sv
test/testbench.sv
